>>> hw/rtl/i2rm_pkg.sv
// i2rm_pkg: types, codes and reset constants for the i2c register read master
// used by every file of the block, no dependencies
package i2rm_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned DEV_ADDR_W = 7;
    localparam int unsigned HALF_W     = 10;
    localparam int unsigned TMO_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'h36;
    localparam logic [HALF_W-1:0]     HALF_RST     = 10'd20;
    localparam logic [TMO_W-1:0]      TMO_RST      = 8'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO      = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_W_LOW   = 4'd3,
        PH_W_HIGH  = 4'd4,
        PH_A_LOW   = 4'd5,
        PH_A_HIGH  = 4'd6,
        PH_RS_LOW  = 4'd7,
        PH_R_LOW   = 4'd8,
        PH_R_HIGH  = 4'd9,
        PH_M_LOW   = 4'd10,
        PH_M_HIGH  = 4'd11,
        PH_P_LOW   = 4'd12,
        PH_P_HIGH  = 4'd13
    } t_phase;

    // which header byte is on the wire
    typedef enum logic [1:0] {
        HDR_DEV_W = 2'd0,
        HDR_REG   = 2'd1,
        HDR_DEV_R = 2'd2
    } t_hdr;

    typedef struct packed {
        logic       opcode;
        logic [7:0] reg_addr;
        logic       two_bytes;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic        scl_level;
        logic        sda_pull_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        ack_error;
    } t_res;

    typedef struct packed {
        logic [DEV_ADDR_W-1:0] device_address;
        logic [HALF_W-1:0]     half_period_ticks;
        logic [TMO_W-1:0]      ack_timeout;
    } t_cfg;

    // classified queue entry
    typedef struct packed {
        logic       is_start;
        logic [7:0] reg_addr;
        logic       two_bytes;
        logic       sda;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

>>> hw/rtl/i2rm_if.sv
// i2rm_in_if / i2rm_out_if: valid-ready channels for input items and results
// depends on i2rm_pkg
interface i2rm_in_if;
    logic              valid;
    logic              ready;
    i2rm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2rm_out_if;
    logic          valid;
    logic          ready;
    i2rm_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/i2rm_front.sv
// i2rm_front: accepts input beats, classifies them and queues them for the back end
// depends on i2rm_pkg
module i2rm_front #(
    parameter int unsigned QUEUE_DEPTH = i2rm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  i2rm_pkg::t_in_item i_data,
    output logic              o_ready,
    output i2rm_pkg::t_q_head o_head,
    input  logic              i_pop
);
    import i2rm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;
    t_cmd             cmd_in;

    assign o_ready = (r_count != CNT_FULL);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    always_comb begin
        cmd_in.is_start  = (i_data.opcode == OP_START);
        cmd_in.reg_addr  = i_data.reg_addr;
        cmd_in.two_bytes = i_data.two_bytes;
        cmd_in.sda       = i_data.sda_in;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

>>> hw/rtl/i2rm_back.sv
// i2rm_back: bus sequencer, one queued beat per cycle unless the result sink stalls, with result register
// depends on i2rm_pkg
module i2rm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2rm_pkg::t_cfg    i_cfg,
    input  i2rm_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_valid,
    output i2rm_pkg::t_res    o_data,
    input  logic              i_ready
);
    import i2rm_pkg::*;

    t_phase      r_phase, n_phase;
    t_hdr        r_stage, n_stage;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [9:0]  r_tick, n_tick;
    logic [7:0]  r_wait, n_wait;
    logic [15:0] r_data, n_data;
    logic        r_byte_idx, n_byte_idx;
    logic [7:0]  r_reg_addr, n_reg_addr;
    logic        r_want_two, n_want_two;
    logic        r_error, n_error;
    logic        n_done;
    logic        r_out_valid;
    t_res        r_out, res;

    logic [9:0]  len, tick_inc;
    logic        over;
    logic [3:0]  bit_inc;
    logic [7:0]  rd_shift;
    logic        step;
    t_cmd        cmd;

    assign cmd   = i_head.cmd;
    assign step  = i_head.valid && (!r_out_valid || i_ready);
    assign o_pop = step;

    // phase length counter, zero length acts as one
    assign len      = (i_cfg.half_period_ticks == '0) ? 10'd1 : i_cfg.half_period_ticks;
    assign tick_inc = r_tick + 10'd1;
    assign over     = (tick_inc >= len) || (tick_inc == '0);
    assign bit_inc  = r_bit_cnt + 4'd1;
    assign rd_shift = {r_shift[6:0], cmd.sda};

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_tick     = r_tick;
        n_wait     = r_wait;
        n_data     = r_data;
        n_byte_idx = r_byte_idx;
        n_reg_addr = r_reg_addr;
        n_want_two = r_want_two;
        n_error    = r_error;
        n_done     = 1'b0;
        if (cmd.is_start) begin
            // start while busy is dropped
            if (r_phase == PH_IDLE) begin
                n_reg_addr = cmd.reg_addr;
                n_want_two = cmd.two_bytes;
                n_error    = 1'b0;
                n_data     = '0;
                n_byte_idx = 1'b0;
                n_bit_cnt  = '0;
                n_wait     = '0;
                n_stage    = HDR_DEV_W;
                n_phase    = PH_START_A;
                n_tick     = '0;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_START_A, PH_W_LOW, PH_A_LOW, PH_R_LOW, PH_M_LOW, PH_P_LOW,
                PH_START_B, PH_W_HIGH, PH_RS_LOW, PH_R_HIGH, PH_M_HIGH,
                PH_P_HIGH: begin
                    n_tick = over ? 10'd0 : tick_inc;
                    if (over) begin
                        case (r_phase)
                            PH_START_A: n_phase = PH_START_B;
                            PH_START_B: begin
                                n_shift   = {i_cfg.device_address, (r_stage == HDR_DEV_R)};
                                n_bit_cnt = '0;
                                n_phase   = PH_W_LOW;
                            end
                            PH_W_LOW: n_phase = PH_W_HIGH;
                            PH_W_HIGH: begin
                                n_shift   = {r_shift[6:0], 1'b0};
                                n_bit_cnt = bit_inc;
                                if (bit_inc >= 4'd8) begin
                                    n_wait  = '0;
                                    n_phase = PH_A_LOW;
                                end else begin
                                    n_phase = PH_W_LOW;
                                end
                            end
                            PH_A_LOW: n_phase = PH_A_HIGH;
                            PH_RS_LOW: begin
                                n_stage = HDR_DEV_R;
                                n_phase = PH_START_A;
                            end
                            PH_R_LOW: n_phase = PH_R_HIGH;
                            PH_R_HIGH: begin
                                n_shift   = rd_shift;
                                n_bit_cnt = bit_inc;
                                if (bit_inc >= 4'd8) begin
                                    n_data  = {r_data[7:0], rd_shift};
                                    n_phase = PH_M_LOW;
                                end else begin
                                    n_phase = PH_R_LOW;
                                end
                            end
                            PH_M_LOW: n_phase = PH_M_HIGH;
                            PH_M_HIGH: begin
                                if (r_want_two && !r_byte_idx) begin
                                    n_byte_idx = 1'b1;
                                    n_bit_cnt  = '0;
                                    n_shift    = '0;
                                    n_phase    = PH_R_LOW;
                                end else begin
                                    n_phase = PH_P_LOW;
                                end
                            end
                            PH_P_LOW: n_phase = PH_P_HIGH;
                            PH_P_HIGH: begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
                PH_A_HIGH: begin
                    // ack poll, one sample per tick
                    if (!cmd.sda) begin
                        n_wait = '0;
                        n_tick = '0;
                        case (r_stage)
                            HDR_DEV_W: begin
                                n_stage   = HDR_REG;
                                n_shift   = r_reg_addr;
                                n_bit_cnt = '0;
                                n_phase   = PH_W_LOW;
                            end
                            HDR_REG: n_phase = PH_RS_LOW;
                            default: begin
                                n_byte_idx = 1'b0;
                                n_bit_cnt  = '0;
                                n_shift    = '0;
                                n_phase    = PH_R_LOW;
                            end
                        endcase
                    end else if (r_wait >= i_cfg.ack_timeout) begin
                        n_error = 1'b1;
                        n_tick  = '0;
                        n_phase = PH_P_LOW;
                    end else begin
                        n_wait = r_wait + 8'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end
    end

    // bus levels and result fields, from the state after this beat
    always_comb begin
        res.busy_res  = (n_phase != PH_IDLE);
        res.done_res  = n_done;
        res.read_data = n_data;
        res.ack_error = n_error;
        case (n_phase)
            PH_START_B: begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
            PH_W_LOW:   begin res.scl_level = 1'b0; res.sda_pull_low = !n_shift[7]; end
            PH_W_HIGH:  begin res.scl_level = 1'b1; res.sda_pull_low = !n_shift[7]; end
            PH_A_LOW:   begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
            PH_A_HIGH:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
            PH_RS_LOW:  begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
            PH_R_LOW:   begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
            PH_R_HIGH:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
            PH_M_LOW: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = n_want_two && !n_byte_idx;
            end
            PH_M_HIGH: begin
                res.scl_level    = 1'b1;
                res.sda_pull_low = n_want_two && !n_byte_idx;
            end
            PH_P_LOW:   begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1; end
            PH_P_HIGH:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
            default:    begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_stage     <= HDR_DEV_W;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_wait      <= '0;
            r_data      <= '0;
            r_byte_idx  <= 1'b0;
            r_reg_addr  <= '0;
            r_want_two  <= 1'b0;
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase    <= n_phase;
                r_stage    <= n_stage;
                r_bit_cnt  <= n_bit_cnt;
                r_shift    <= n_shift;
                r_tick     <= n_tick;
                r_wait     <= n_wait;
                r_data     <= n_data;
                r_byte_idx <= n_byte_idx;
                r_reg_addr <= n_reg_addr;
                r_want_two <= n_want_two;
                r_error    <= n_error;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/i2c_register_read_master.sv
// i2c register read master: every accepted beat (tick or start) gives one result beat
// path: an accepted beat is queued, then stepped through the sequencer into the result register
// throughput: one beat per cycle while the sink is ready, the result register refills while the sink takes it
// the input queue lets the sequencer and the input side stall independently
// reset: synchronous active low, clears the queue, the sequencer and the config to defaults
// depends on i2rm_pkg, i2rm_if, i2rm_front, i2rm_back
module i2c_register_read_master #(
    parameter int unsigned QUEUE_DEPTH = i2rm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    i2rm_in_if.sink                            i_item,
    i2rm_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [i2rm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2rm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import i2rm_pkg::*;

    t_cfg    r_cfg;
    t_q_head head;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address    <= DEV_ADDR_RST;
            r_cfg.half_period_ticks <= HALF_RST;
            r_cfg.ack_timeout       <= TMO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEV_ADDR: r_cfg.device_address    <= i_cfg_wdata[DEV_ADDR_W-1:0];
                CFG_HALF:     r_cfg.half_period_ticks <= i_cfg_wdata[HALF_W-1:0];
                CFG_TMO:      r_cfg.ack_timeout       <= i_cfg_wdata[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    i2rm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_data  (i_item.data),
        .o_ready (i_item.ready),
        .o_head  (head),
        .i_pop   (pop)
    );

    i2rm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_res.valid),
        .o_data  (o_res.data),
        .i_ready (o_res.ready)
    );

endmodule

>>> hw/rtl/i2rm_checker.sv
// i2rm_checker: port-level checks on the result channel, bound to the top level
// depends on i2rm_pkg
module i2rm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input i2rm_pkg::t_res i_out_data
);
    import i2rm_pkg::*;

    // result register empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result beat changed");

    // the beat that ends a transaction is no longer busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.done_res |-> !i_out_data.busy_res)
        else $error("done beat still busy");

    // an idle bus is released with scl high
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.busy_res |->
            i_out_data.scl_level && !i_out_data.sda_pull_low)
        else $error("bus driven while idle");

endmodule

bind i2c_register_read_master i2rm_checker u_i2rm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

>>> sim/tb_i2c_register_read_master.sv
`timescale 1ns / 1ps
// tb_i2c_register_read_master: self-checking bench for the i2c register read master
// tick and start beats come from a reactive slave stand-in; each result beat is checked
// against a cycle-free model of the sequencer; needs i2rm_pkg, i2rm_if and the rtl
module tb_i2c_register_read_master;
    import i2rm_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic [DEV_ADDR_W-1:0] dev;
        logic [HALF_W-1:0]     half;
        logic [TMO_W-1:0]      tmo;
        t_phase                ph;
        t_hdr                  hdr;
        logic [3:0]            bits;
        logic [7:0]            shreg;
        logic [HALF_W-1:0]     ticks;
        logic [7:0]            waits;
        logic [15:0]           data;
        logic                  second;
        logic [7:0]            raddr;
        logic                  two;
        logic                  err;
    } t_master_model;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    i2rm_in_if  item_if ();
    i2rm_out_if res_if ();

    i2c_register_read_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror tracks accepted beats, lookahead tracks generated ones
    t_master_model mirror;
    t_master_model lookahead;
    t_in_item      cmd_q[$];
    t_res          bus_state_q[$];
    t_res          res_want;
    int unsigned   n_sent, n_checked, n_fail, n_done, n_abort, idle_cycles;
    int unsigned   in_gap, in_calm, out_hold, out_calm;
    bit            in_took;
    bit            slave_absent;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_master_model model_reset();
        t_master_model m;
        m      = '0;
        m.dev  = DEV_ADDR_RST;
        m.half = HALF_RST;
        m.tmo  = TMO_RST;
        m.ph   = PH_IDLE;
        m.hdr  = HDR_DEV_W;
        return m;
    endfunction

    function automatic void set_reg(inout t_master_model m, input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_DEV_ADDR: m.dev  = val[DEV_ADDR_W-1:0];
            CFG_HALF:     m.half = val[HALF_W-1:0];
            CFG_TMO:      m.tmo  = val[TMO_W-1:0];
            default: ;
        endcase
    endfunction

    // counts one tick of a timed phase; a zero half period acts as one tick
    function automatic bit span_over(inout t_master_model m);
        logic [HALF_W-1:0] len;
        len     = (m.half == '0) ? HALF_W'(1) : m.half;
        m.ticks = m.ticks + 1'b1;
        if (m.ticks >= len || m.ticks == '0) begin
            m.ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter(inout t_master_model m, input t_phase next);
        m.ph    = next;
        m.ticks = '0;
    endfunction

    function automatic void load_byte(inout t_master_model m, input logic [7:0] b);
        m.shreg = b;
        m.bits  = '0;
        enter(m, PH_W_LOW);
    endfunction

    function automatic bit master_acks(input t_master_model m);
        return m.two && !m.second;
    endfunction

    function automatic t_res master_step(inout t_master_model m, input t_in_item it);
        t_res r;
        logic done;
        done = 1'b0;
        if (it.opcode == OP_START) begin
            // a start while busy changes nothing
            if (m.ph == PH_IDLE) begin
                m.raddr  = it.reg_addr;
                m.two    = it.two_bytes;
                m.err    = 1'b0;
                m.data   = '0;
                m.second = 1'b0;
                m.bits   = '0;
                m.waits  = '0;
                m.hdr    = HDR_DEV_W;
                enter(m, PH_START_A);
            end
        end else begin
            case (m.ph)
                PH_IDLE: ;
                PH_START_A: if (span_over(m)) enter(m, PH_START_B);
                PH_START_B: if (span_over(m)) load_byte(m, {m.dev, (m.hdr == HDR_DEV_R)});
                PH_W_LOW:   if (span_over(m)) enter(m, PH_W_HIGH);
                PH_W_HIGH: begin
                    if (span_over(m)) begin
                        m.shreg = m.shreg << 1;
                        m.bits  = m.bits + 1'b1;
                        if (m.bits >= 4'd8) begin
                            m.waits = '0;
                            enter(m, PH_A_LOW);
                        end else begin
                            enter(m, PH_W_LOW);
                        end
                    end
                end
                PH_A_LOW:   if (span_over(m)) enter(m, PH_A_HIGH);
                PH_A_HIGH: begin
                    // slave ack is polled once per tick, no phase timing here
                    if (it.sda_in == 1'b0) begin
                        m.waits = '0;
                        case (m.hdr)
                            HDR_DEV_W: begin
                                m.hdr = HDR_REG;
                                load_byte(m, m.raddr);
                            end
                            HDR_REG: enter(m, PH_RS_LOW);
                            default: begin
                                m.second = 1'b0;
                                m.bits   = '0;
                                m.shreg  = '0;
                                enter(m, PH_R_LOW);
                            end
                        endcase
                    end else if (m.waits >= m.tmo) begin
                        m.err = 1'b1;
                        enter(m, PH_P_LOW);
                    end else begin
                        m.waits = m.waits + 1'b1;
                    end
                end
                PH_RS_LOW: begin
                    if (span_over(m)) begin
                        m.hdr = HDR_DEV_R;
                        enter(m, PH_START_A);
                    end
                end
                PH_R_LOW:   if (span_over(m)) enter(m, PH_R_HIGH);
                PH_R_HIGH: begin
                    if (span_over(m)) begin
                        m.shreg = {m.shreg[6:0], it.sda_in};
                        m.bits  = m.bits + 1'b1;
                        if (m.bits >= 4'd8) begin
                            m.data = {m.data[7:0], m.shreg};
                            enter(m, PH_M_LOW);
                        end else begin
                            enter(m, PH_R_LOW);
                        end
                    end
                end
                PH_M_LOW:   if (span_over(m)) enter(m, PH_M_HIGH);
                PH_M_HIGH: begin
                    if (span_over(m)) begin
                        if (master_acks(m)) begin
                            m.second = 1'b1;
                            m.bits   = '0;
                            m.shreg  = '0;
                            enter(m, PH_R_LOW);
                        end else begin
                            enter(m, PH_P_LOW);
                        end
                    end
                end
                PH_P_LOW:   if (span_over(m)) enter(m, PH_P_HIGH);
                PH_P_HIGH: begin
                    if (span_over(m)) begin
                        enter(m, PH_IDLE);
                        done = 1'b1;
                    end
                end
                default: enter(m, PH_IDLE);
            endcase
        end

        r.scl_level    = 1'b1;
        r.sda_pull_low = 1'b0;
        case (m.ph)
            PH_START_B: r.sda_pull_low = 1'b1;
            PH_W_LOW: begin
                r.scl_level    = 1'b0;
                r.sda_pull_low = ~m.shreg[7];
            end
            PH_W_HIGH: r.sda_pull_low = ~m.shreg[7];
            PH_A_LOW, PH_RS_LOW, PH_R_LOW: r.scl_level = 1'b0;
            PH_M_LOW: begin
                r.scl_level    = 1'b0;
                r.sda_pull_low = master_acks(m);
            end
            PH_M_HIGH: r.sda_pull_low = master_acks(m);
            PH_P_LOW: begin
                r.scl_level    = 1'b0;
                r.sda_pull_low = 1'b1;
            end
            PH_P_HIGH: r.sda_pull_low = 1'b1;
            default: ;
        endcase
        r.busy_res  = (m.ph != PH_IDLE);
        r.done_res  = done;
        r.read_data = m.data;
        r.ack_error = m.err;
        return r;
    endfunction

    function automatic void compare_res(input t_res want, input t_res got);
        if (got.scl_level !== want.scl_level) begin
            $error("scl_level: expected %0b, got %0b", want.scl_level, got.scl_level);
            n_fail++;
        end
        if (got.sda_pull_low !== want.sda_pull_low) begin
            $error("sda_pull_low: expected %0b, got %0b", want.sda_pull_low, got.sda_pull_low);
            n_fail++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            n_fail++;
        end
        if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
            n_fail++;
        end
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected %04h, got %04h", want.read_data, got.read_data);
            n_fail++;
        end
        if (got.ack_error !== want.ack_error) begin
            $error("ack_error: expected %0b, got %0b", want.ack_error, got.ack_error);
            n_fail++;
        end
    endfunction

    // mostly back to back, some short gaps, rare long ones, and calm stretches
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // slave stand-in: acks after a short random wait unless it plays absent
    function automatic logic slave_bit();
        if (lookahead.ph == PH_A_HIGH)
            return slave_absent ? 1'b1 : ($urandom_range(0, 3) == 0);
        return 1'($urandom);
    endfunction

    function automatic void send(input logic op, input logic [7:0] ra, input logic two,
                                 input logic sda);
        t_in_item it;
        it.opcode    = op;
        it.reg_addr  = ra;
        it.two_bytes = two;
        it.sda_in    = sda;
        void'(master_step(lookahead, it));
        cmd_q.push_back(it);
        n_sent++;
    endfunction

    task automatic wait_drained();
        while (n_checked != n_sent) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        set_reg(mirror, idx, val);
        set_reg(lookahead, idx, val);
    endtask

    // transactions with a live or absent slave, plus starts thrown in while busy and idle ticks
    task automatic run_traffic(input int unsigned n_useful);
        int unsigned got;
        got = 0;
        while (got < n_useful) begin
            if (lookahead.ph == PH_IDLE) begin
                repeat ($urandom_range(0, 2))
                    send(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
                slave_absent = ($urandom_range(0, 99) < 12);
                send(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
                got++;
            end else if ($urandom_range(0, 99) < 4) begin
                send(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send(OP_TICK, 8'($urandom), 1'($urandom), slave_bit());
                got++;
            end
        end
    endtask

    task automatic run_phase(input logic [DEV_ADDR_W-1:0] dev, input logic [HALF_W-1:0] half,
                             input logic [TMO_W-1:0] tmo, input int unsigned n_useful);
        wait_drained();
        write_reg(CFG_DEV_ADDR, CFG_DATA_W'(dev));
        write_reg(CFG_HALF, CFG_DATA_W'(half));
        write_reg(CFG_TMO, CFG_DATA_W'(tmo));
        run_traffic(n_useful);
    endtask

    // input side: hold a beat until taken, then maybe idle before the next
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!item_if.valid || in_took) begin
                if (in_gap > 0) begin
                    in_gap--;
                    item_if.valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    item_if.data  <= cmd_q.pop_front();
                    item_if.valid <= 1'b1;
                    in_gap = pick_gap(in_calm);
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_hold > 0) begin
                out_hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                out_hold = pick_gap(out_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        in_took = item_if.valid && item_if.ready;
        if (i_rst_n) begin
            if (in_took)
                bus_state_q.push_back(master_step(mirror, item_if.data));
            if (res_if.valid && res_if.ready) begin
                if (bus_state_q.size() == 0) begin
                    $error("result beat arrived with nothing outstanding");
                    n_fail++;
                end else begin
                    res_want = bus_state_q.pop_front();
                    compare_res(res_want, res_if.data);
                    n_checked++;
                    if (res_want.done_res) begin
                        n_done++;
                        if (res_want.ack_error) n_abort++;
                    end
                end
            end
            if (in_took || (res_if.valid && res_if.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        n_sent       = 0;
        n_checked    = 0;
        n_fail       = 0;
        n_done       = 0;
        n_abort      = 0;
        idle_cycles  = 0;
        in_gap       = 0;
        in_calm      = 0;
        out_hold     = 0;
        out_calm     = 0;
        slave_absent = 1'b0;
        mirror       = model_reset();
        lookahead    = model_reset();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        res_if.ready  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero half period, zero timeout, all-ones address: abort on the first high ack sample
        write_reg(CFG_DEV_ADDR, CFG_DATA_W'(7'h7F));
        write_reg(CFG_HALF, '0);
        write_reg(CFG_TMO, '0);
        send(OP_TICK, 8'h00, 1'b0, 1'b0);
        send(OP_TICK, 8'hFF, 1'b1, 1'b1);
        send(OP_START, 8'hFF, 1'b1, 1'b0);
        send(OP_START, 8'h00, 1'b0, 1'b1);
        while (lookahead.ph != PH_IDLE) send(OP_TICK, 8'h00, 1'b0, 1'b1);

        run_phase(7'h00, 10'd1, 8'd255, 300);
        run_phase(7'h7F, 10'd2, 8'd3, 250);
        run_phase(7'($urandom), 10'd0, 8'd1, 250);
        // very long phases, then shrink the half period while a phase is under way
        run_phase(7'($urandom), 10'd1023, 8'($urandom), 150);
        run_phase(7'($urandom), 10'd2, 8'($urandom), 300);
        run_phase(7'($urandom), 10'($urandom_range(1, 4)), 8'd0, 200);
        run_phase(DEV_ADDR_RST, 10'd1, 8'($urandom_range(1, 255)), 200);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (bus_state_q.size() != 0) begin
            $error("%0d result beats never arrived", bus_state_q.size());
            n_fail++;
        end
        $display("run: %0d beats driven, %0d result beats compared, %0d mismatches",
                 n_sent, n_checked, n_fail);
        $display("run: %0d transfers ended, %0d of them on a missing slave ack",
                 n_done, n_abort);
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
